@@ src/cigar_interval_walker_assert.svh @@
// ----------------------------------------------------------------------------
// CIGAR interval walker assertion macros
// Shared property wrappers; each expands to one labeled concurrent assertion
// clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIGAR_INTERVAL_WALKER_ASSERT_SVH
`define CIGAR_INTERVAL_WALKER_ASSERT_SVH

// Check cons in the same cycle that ante holds.
`define CIGW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define CIGW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/cigw_pkg.sv @@
// ----------------------------------------------------------------------------
// CIGAR interval walker package
// Operation and interval codes, position limit and the transaction structs.
// ----------------------------------------------------------------------------
package cigw_pkg;

    localparam int unsigned POS_W = 31;
    localparam int unsigned LEN_W = 28;
    localparam int unsigned OP_W  = 4;
    localparam int unsigned KIND_W = 3;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // SAM operation codes
    localparam logic [OP_W-1:0] OP_M  = 4'd0;
    localparam logic [OP_W-1:0] OP_I  = 4'd1;
    localparam logic [OP_W-1:0] OP_D  = 4'd2;
    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_S  = 4'd4;
    localparam logic [OP_W-1:0] OP_H  = 4'd5;
    localparam logic [OP_W-1:0] OP_P  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;

    // Interval kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPLICE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INS    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LCLIP  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RCLIP  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op_code;
        logic [LEN_W-1:0] op_length;
        logic             is_first;
        logic             is_last;
        logic [POS_W-1:0] align_start;
    } cigw_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  interval_kind;
        logic signed [31:0] span_start;
        logic [POS_W-1:0]   span_end;
        logic [POS_W-1:0]   reference_end;
        logic [POS_W-1:0]   query_length;
        logic               read_done;
        logic               overflow;
    } cigw_result_t;

endpackage

@@ src/cigw_step.sv @@
// ----------------------------------------------------------------------------
// CIGAR interval walker step logic
// Advances both cursors by one operation and forms its interval, all
// saturating sums computed side by side from the cursor before the operation.
// ----------------------------------------------------------------------------
module cigw_step
    import cigw_pkg::*;
(
    input  cigw_item_t       item,
    input  logic [POS_W-1:0] ref_cursor,
    input  logic [POS_W-1:0] query_cursor,
    output cigw_result_t     result,
    output logic [POS_W-1:0] ref_next,
    output logic [POS_W-1:0] query_next
);

    logic [POS_W-1:0] base;
    logic [POS_W-1:0] qbase;
    logic [POS_W:0]   ref_sum;
    logic [POS_W:0]   qry_sum;
    logic             ref_sat;
    logic             qry_sat;
    logic [POS_W-1:0] ref_sat_val;
    logic [POS_W-1:0] qry_sat_val;
    logic             adv_ref;
    logic             adv_qry;
    logic [POS_W-1:0] back_span;
    logic [POS_W-1:0] ins_end;
    logic [31:0]      ins_start;
    logic [31:0]      clip_diff;
    logic [31:0]      clip_start;
    logic             base_max;

    always_comb
    begin
        base  = item.is_first ? item.align_start : ref_cursor;
        qbase = item.is_first ? '0 : query_cursor;

        adv_ref = (item.op_code == OP_M) || (item.op_code == OP_D) ||
                  (item.op_code == OP_N) || (item.op_code == OP_EQ) ||
                  (item.op_code == OP_X);
        adv_qry = (item.op_code == OP_M) || (item.op_code == OP_I) ||
                  (item.op_code == OP_S) || (item.op_code == OP_EQ) ||
                  (item.op_code == OP_X);

        ref_sum     = {1'b0, base} + {{(POS_W+1-LEN_W){1'b0}}, item.op_length};
        qry_sum     = {1'b0, qbase} + {{(POS_W+1-LEN_W){1'b0}}, item.op_length};
        ref_sat     = ref_sum[POS_W];
        qry_sat     = qry_sum[POS_W];
        ref_sat_val = ref_sat ? POS_MAX : ref_sum[POS_W-1:0];
        qry_sat_val = qry_sat ? POS_MAX : qry_sum[POS_W-1:0];

        ref_next   = adv_ref ? ref_sat_val : base;
        query_next = adv_qry ? qry_sat_val : qbase;

        // Start of a span ending at the advanced cursor: the old cursor,
        // unless the advance saturated.
        back_span = ref_sat ? (POS_MAX - {{(POS_W-LEN_W){1'b0}}, item.op_length}) : base;

        base_max  = (base == POS_MAX);
        ins_end   = base_max ? POS_MAX : (base + {{(POS_W-1){1'b0}}, 1'b1});
        ins_start = {1'b0, base} - 32'd1;
        clip_diff = {1'b0, base} - {{(32-LEN_W){1'b0}}, item.op_length};
        clip_start = clip_diff[31] ? 32'd0 : clip_diff;

        result.interval_kind = KIND_NONE;
        result.span_start    = '0;
        result.span_end      = '0;
        result.reference_end = ref_next;
        result.query_length  = query_next;
        result.read_done     = item.is_last;
        result.overflow      = (adv_ref && ref_sat) || (adv_qry && qry_sat);

        case (item.op_code) inside
            OP_M, OP_EQ, OP_X:
            begin
                result.interval_kind = KIND_MATCH;
                result.span_start    = {1'b0, back_span};
                result.span_end      = ref_next;
            end
            OP_N:
            begin
                if (!item.is_first && !item.is_last)
                begin
                    result.interval_kind = KIND_SPLICE;
                    result.span_start    = {1'b0, back_span};
                    result.span_end      = ref_next;
                end
            end
            OP_I:
            begin
                result.interval_kind = KIND_INS;
                result.span_start    = ins_start;
                result.span_end      = ins_end;
                result.overflow      = result.overflow || base_max;
            end
            OP_D:
            begin
                result.interval_kind = KIND_DEL;
                result.span_start    = {1'b0, back_span};
                result.span_end      = ref_next;
            end
            OP_S:
            begin
                if (item.is_first)
                begin
                    result.interval_kind = KIND_LCLIP;
                    result.span_start    = clip_start;
                    result.span_end      = base;
                end
                else if (item.is_last)
                begin
                    result.interval_kind = KIND_RCLIP;
                    result.span_start    = {1'b0, base};
                    result.span_end      = ref_sat_val;
                    result.overflow      = result.overflow || ref_sat;
                end
                else
                begin
                    result.interval_kind = KIND_ERROR;
                end
            end
            OP_H:
            begin
                result.interval_kind = KIND_ERROR;
            end
            default:
            begin
                result.interval_kind = KIND_NONE;
            end
        endcase
    end

endmodule

@@ src/cigar_interval_walker.sv @@
// ----------------------------------------------------------------------------
// CIGAR interval walker
// Walks the CIGAR operations of aligned reads and reports one interval each.
// ----------------------------------------------------------------------------
// Feed one CIGAR operation per transaction, the first of each read flagged
// with is_first and carrying align_start, the last flagged with is_last. The
// block answers every operation with exactly one result transaction, in order:
// the interval kind and span, the reference cursor and query length after the
// operation, and read_done on the last one. Throughput is one operation per
// cycle while result_stall stays low. result_valid rises once the operation
// has passed the input register and then, through the step logic and cursor
// update, the result register, which holds it while result_stall is high.
// The cursor loop closes through one 32-bit saturating add, which is what
// sets the rate. An operation without is_first continues from the cursors
// the previous operation left behind, including right after reset, where
// both cursors are zero. Positions saturate at 2^31-1 and raise overflow on
// that result.
module cigar_interval_walker
    import cigw_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Operation channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [OP_W-1:0]          op_code,
    input  logic [LEN_W-1:0]         op_length,
    input  logic                     is_first,
    input  logic                     is_last,
    input  logic [POS_W-1:0]         align_start,

    // Interval channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [KIND_W-1:0]        interval_kind,
    output logic signed [31:0]       span_start,
    output logic [POS_W-1:0]         span_end,
    output logic [POS_W-1:0]         reference_end,
    output logic [POS_W-1:0]         query_length,
    output logic                     read_done,
    output logic                     overflow
);

`include "cigar_interval_walker_assert.svh"

    // Input stage
    logic         in_valid_reg;
    cigw_item_t   in_item_reg;

    // Result stage
    logic         out_valid_reg;
    cigw_result_t out_result_reg;

    // Running cursors, updated as an operation leaves the input stage
    logic [POS_W-1:0] ref_cursor_reg;
    logic [POS_W-1:0] query_cursor_reg;

    cigw_result_t     step_result;
    logic [POS_W-1:0] ref_cursor_next;
    logic [POS_W-1:0] query_cursor_next;

    logic         out_load;
    logic         in_load;
    logic         step_fire;

    // The result register takes a new value whenever it is empty or its
    // current transaction is being taken; the input stage then drains into it.
    assign out_load  = !out_valid_reg || !result_stall;
    assign step_fire = in_valid_reg && out_load;

    // Hold the input only while a stalled operation still sits in the input
    // stage; otherwise keep taking a new operation every cycle.
    assign item_stall = in_valid_reg && !out_load;
    assign in_load    = item_valid && !item_stall;

    cigw_step u_step (
        .item         (in_item_reg),
        .ref_cursor   (ref_cursor_reg),
        .query_cursor (query_cursor_reg),
        .result       (step_result),
        .ref_next     (ref_cursor_next),
        .query_next   (query_cursor_next)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            ref_cursor_reg   <= '0;
            query_cursor_reg <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Advance the cursors only when an operation actually moves on.
            if (step_fire)
            begin
                ref_cursor_reg   <= ref_cursor_next;
                query_cursor_reg <= query_cursor_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg.op_code     <= op_code;
            in_item_reg.op_length   <= op_length;
            in_item_reg.is_first    <= is_first;
            in_item_reg.is_last     <= is_last;
            in_item_reg.align_start <= align_start;
        end
        if (step_fire)
        begin
            out_result_reg <= step_result;
        end
    end

    assign result_valid  = out_valid_reg;
    assign interval_kind = out_result_reg.interval_kind;
    assign span_start    = out_result_reg.span_start;
    assign span_end      = out_result_reg.span_end;
    assign reference_end = out_result_reg.reference_end;
    assign query_length  = out_result_reg.query_length;
    assign read_done     = out_result_reg.read_done;
    assign overflow      = out_result_reg.overflow;

    // Assertions
    `CIGW_ASSERT_NOW(a_stall_only_when_full, item_stall, in_valid_reg, "input stalled while empty")

    `CIGW_ASSERT_NEXT(a_cursor_tracks_result, step_fire,
        ref_cursor_reg == reference_end && query_cursor_reg == query_length,
        "cursor does not match delivered result")

    `CIGW_ASSERT_NOW(a_unused_span_zero,
        out_valid_reg && (interval_kind == KIND_NONE || interval_kind == KIND_ERROR),
        span_start == 32'sd0 && span_end == '0,
        "unused span not cleared")

    `CIGW_ASSERT_NOW(a_overflow_saturated, out_valid_reg && overflow,
        reference_end == POS_MAX || query_length == POS_MAX || span_end == POS_MAX,
        "overflow without a saturated value")

    `CIGW_ASSERT_NOW(a_match_ends_at_cursor, out_valid_reg && interval_kind == KIND_MATCH,
        span_end == reference_end,
        "match span does not end at reference cursor")

endmodule
